FILE: hdl/art_pkg.sv
// Shared types and constants for the address region table.
// Holds the operation and status codes, controller states, the stored
// entry layout and the result bundle. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package art_pkg;

  localparam int ADDR_W  = 32;
  localparam int FLAG_W  = 8;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rstart;
    logic [ADDR_W-1:0] rend;
    logic [FLAG_W-1:0] rflags;
  } entry_t;

  typedef struct packed {
    logic               hit;
    status_t            status;
    logic [ADDR_W-1:0]  found_start;
    logic [ADDR_W-1:0]  found_end;
    logic [FLAG_W-1:0]  found_flags;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/art_mem.sv
// Region store: one synchronous memory of entries, one write and one read
// port, read data registered.
// Depends on art_pkg for the entry layout.
`timescale 1ns / 1ps
`default_nettype none

module art_mem #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire art_pkg::entry_t  wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output art_pkg::entry_t       rd_data
);

  art_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/art_ctrl.sv
// Request sequencer for the region table: scans the store, checks inserts,
// shifts entries up to open a slot and builds one result per request.
// Depends on art_pkg; drives the ports of art_mem.
`timescale 1ns / 1ps
`default_nettype none

module art_ctrl #(
  parameter int MAX_REGIONS = 16,
  parameter int IDX_W       = 4,
  parameter int CNT_W       = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   operation,
  input  wire logic [art_pkg::ADDR_W-1:0]   start_or_address,
  input  wire logic [art_pkg::ADDR_W-1:0]   end_address,
  input  wire logic [art_pkg::FLAG_W-1:0]   region_flags_in,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output art_pkg::result_t                  res,
  output logic                              rd_en,
  output logic [IDX_W-1:0]                  rd_addr,
  input  wire art_pkg::entry_t              rd_data,
  output logic                              wr_en,
  output logic [IDX_W-1:0]                  wr_addr,
  output art_pkg::entry_t                   wr_data
);

  localparam int CW = CNT_W + art_pkg::COUNT_W;

  art_pkg::state_t  state, state_next;
  art_pkg::status_t st, st_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] iss, iss_next;
  logic [CNT_W-1:0] pos, pos_next;
  logic [CNT_W-1:0] wa, wa_next;
  logic             rd_pend, rd_pend_next;
  logic             iss_done, iss_done_next;
  logic             ovl, ovl_next;
  logic             hit_q, hit_q_next;
  logic [art_pkg::ADDR_W-1:0] fstart, fstart_next;
  logic [art_pkg::ADDR_W-1:0] fend, fend_next;
  logic [art_pkg::FLAG_W-1:0] fflags, fflags_next;
  logic [1:0]                 op_q, op_q_next;
  logic [art_pkg::ADDR_W-1:0] a_q, a_q_next;
  logic [art_pkg::ADDR_W-1:0] b_q, b_q_next;
  logic [art_pkg::FLAG_W-1:0] f_q, f_q_next;
  logic [CW-1:0]              cnt_ext;

  always_comb begin
    state_next    = state;
    st_next       = st;
    cnt_next      = cnt;
    iss_next      = iss;
    pos_next      = pos;
    wa_next       = wa;
    rd_pend_next  = 1'b0;
    iss_done_next = iss_done;
    ovl_next      = ovl;
    hit_q_next    = hit_q;
    fstart_next   = fstart;
    fend_next     = fend;
    fflags_next   = fflags;
    op_q_next     = op_q;
    a_q_next      = a_q;
    b_q_next      = b_q;
    f_q_next      = f_q;
    rd_en         = 1'b0;
    rd_addr       = iss[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = wa[IDX_W-1:0];
    wr_data       = rd_data;
    in_stall      = (state != art_pkg::S_IDLE);
    res_valid     = 1'b0;

    unique case (state)
      art_pkg::S_IDLE: begin
        if (in_valid) begin
          op_q_next    = operation;
          a_q_next     = start_or_address;
          b_q_next     = end_address;
          f_q_next     = region_flags_in;
          st_next      = art_pkg::ST_OK;
          hit_q_next   = 1'b0;
          fstart_next  = '0;
          fend_next    = '0;
          fflags_next  = '0;
          ovl_next     = 1'b0;
          pos_next     = '0;
          iss_next     = '0;
          unique case (operation)
            art_pkg::OP_INSERT: begin
              if (start_or_address >= end_address) begin
                st_next    = art_pkg::ST_EMPTY;
                state_next = art_pkg::S_RESP;
              end else begin
                state_next = art_pkg::S_SCAN;
              end
            end
            art_pkg::OP_LOOKUP: state_next = art_pkg::S_SCAN;
            art_pkg::OP_CLEAR: begin
              cnt_next   = '0;
              state_next = art_pkg::S_RESP;
            end
            default: state_next = art_pkg::S_RESP;
          endcase
        end
      end

      art_pkg::S_SCAN: begin
        // issue one read per cycle, evaluate each entry in the cycle after its read
        if (iss != cnt) begin
          rd_en        = 1'b1;
          rd_pend_next = 1'b1;
          iss_next     = iss + 1'b1;
        end
        if (rd_pend) begin
          if (op_q == art_pkg::OP_LOOKUP) begin
            if (!hit_q && rd_data.rstart <= a_q && a_q < rd_data.rend) begin
              hit_q_next  = 1'b1;
              fstart_next = rd_data.rstart;
              fend_next   = rd_data.rend;
              fflags_next = rd_data.rflags;
            end
          end else begin
            if (rd_data.rstart <= a_q) begin
              pos_next = pos + 1'b1;
            end
            if (rd_data.rstart < b_q && rd_data.rend > a_q) begin
              ovl_next = 1'b1;
            end
          end
        end
        if (iss == cnt && !rd_pend) begin
          if (op_q == art_pkg::OP_LOOKUP) begin
            state_next = art_pkg::S_RESP;
          end else if (ovl) begin
            st_next    = art_pkg::ST_OVERLAP;
            state_next = art_pkg::S_RESP;
          end else if (cnt == CNT_W'(MAX_REGIONS)) begin
            st_next    = art_pkg::ST_FULL;
            state_next = art_pkg::S_RESP;
          end else if (pos == cnt) begin
            state_next = art_pkg::S_WRITE;
          end else begin
            iss_next      = cnt - 1'b1;
            iss_done_next = 1'b0;
            state_next    = art_pkg::S_SHIFT;
          end
        end
      end

      art_pkg::S_SHIFT: begin
        // move entries pos..cnt-1 up by one, top first; read i, write i+1
        if (!iss_done) begin
          rd_en        = 1'b1;
          rd_pend_next = 1'b1;
          wa_next      = iss + 1'b1;
          if (iss == pos) begin
            iss_done_next = 1'b1;
          end else begin
            iss_next = iss - 1'b1;
          end
        end
        if (rd_pend) begin
          wr_en = 1'b1;
        end
        if (iss_done && !rd_pend) begin
          state_next = art_pkg::S_WRITE;
        end
      end

      art_pkg::S_WRITE: begin
        wr_en      = 1'b1;
        wr_addr    = pos[IDX_W-1:0];
        wr_data    = '{rstart: a_q, rend: b_q, rflags: f_q};
        cnt_next   = cnt + 1'b1;
        state_next = art_pkg::S_RESP;
      end

      art_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = art_pkg::S_IDLE;
        end
      end

      default: state_next = art_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= art_pkg::S_IDLE;
      cnt      <= '0;
      rd_pend  <= 1'b0;
      iss_done <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      rd_pend  <= rd_pend_next;
      iss_done <= iss_done_next;
    end
  end

  always_ff @(posedge clk) begin
    st     <= st_next;
    iss    <= iss_next;
    pos    <= pos_next;
    wa     <= wa_next;
    ovl    <= ovl_next;
    hit_q  <= hit_q_next;
    fstart <= fstart_next;
    fend   <= fend_next;
    fflags <= fflags_next;
    op_q   <= op_q_next;
    a_q    <= a_q_next;
    b_q    <= b_q_next;
    f_q    <= f_q_next;
  end

  assign cnt_ext = CW'(cnt);

  always_comb begin
    res.hit         = hit_q;
    res.status      = st;
    res.found_start = fstart;
    res.found_end   = fend;
    res.found_flags = fflags;
    res.count       = cnt_ext[art_pkg::COUNT_W-1:0];
  end

  a_no_rw_same: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en && rd_addr == wr_addr))
    else $error("read and write hit the same entry in one cycle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == art_pkg::S_WRITE) |=> (cnt == $past(cnt) + 1'b1))
    else $error("successful insert did not advance the count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_REGIONS))
    else $error("region count exceeds table depth");

  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    (state == art_pkg::S_SHIFT) |-> (pos < cnt && cnt < CNT_W'(MAX_REGIONS)))
    else $error("shift started without a free slot above the insert point");

endmodule

`default_nettype wire

FILE: hdl/address_region_table.sv
// Address region table: a sorted store of up to MAX_REGIONS non-overlapping
// half-open address ranges [start, end), each with a flags byte.
//
// Request channel (in_valid / in_stall, payload operation, start_or_address,
// end_address, region_flags_in) takes insert, lookup and clear requests. A
// request is taken when in_valid is high and in_stall is low. Each request
// gives exactly one result on the result channel (out_valid / out_stall):
// hit, status, found_start/end/flags and region_count.
// Clear, the unused code and an empty range go straight to the result; a
// lookup scans the stored regions, and an insert scans them and may then
// move the entries above its place up one by one to open its slot. Both go
// through the single read port of the region memory: the scan and the shift
// read one entry per cycle. One request is in work at a time; in_stall is
// high while it is.
// The finished result sits in an output register, so a new request is taken
// while the receiver holds out_stall; the next result waits in the
// sequencer until that register frees up, and out_valid and the payload hold.
// Reset (rst, synchronous) empties the table and drops any pending result;
// the region memory itself is not cleared, only the count.
`timescale 1ns / 1ps
`default_nettype none

module address_region_table #(
  parameter int MAX_REGIONS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 operation,
  input  wire logic [art_pkg::ADDR_W-1:0] start_or_address,
  input  wire logic [art_pkg::ADDR_W-1:0] end_address,
  input  wire logic [art_pkg::FLAG_W-1:0] region_flags_in,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            hit,
  output logic [1:0]                      status,
  output logic [art_pkg::ADDR_W-1:0]      found_start,
  output logic [art_pkg::ADDR_W-1:0]      found_end,
  output logic [art_pkg::FLAG_W-1:0]      found_flags,
  output logic [art_pkg::COUNT_W-1:0]     region_count
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  logic             res_valid;
  logic             res_ready;
  art_pkg::result_t res;
  art_pkg::result_t out_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  art_pkg::entry_t  rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  art_pkg::entry_t  wr_data;

  art_ctrl #(
    .MAX_REGIONS (MAX_REGIONS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .start_or_address (start_or_address),
    .end_address      (end_address),
    .region_flags_in  (region_flags_in),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data)
  );

  art_mem #(
    .DEPTH (MAX_REGIONS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: load when empty or being drained this cycle; hold
  // while the receiver stalls.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign hit          = out_q.hit;
  assign status       = out_q.status;
  assign found_start  = out_q.found_start;
  assign found_end    = out_q.found_end;
  assign found_flags  = out_q.found_flags;
  assign region_count = out_q.count;

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> out_valid)
    else $error("result taken from sequencer but not presented");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_stall)
    else $error("request channel open while a result is pending");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (found_start == '0 && found_end == '0 && found_flags == '0))
    else $error("miss carries nonzero region fields");

endmodule

`default_nettype wire
